// File: hw/rtl/sitoa_pkg.sv
// ----------------------------------------------------------------------------
// sitoa_pkg
// Shared types and constants of the signed integer to decimal ASCII converter.
// ----------------------------------------------------------------------------
package sitoa_pkg;

   localparam int BinWidth      = 32;
   localparam int NumDigits     = 10;
   localparam int DigitIdxWidth = $clog2(NumDigits);
   localparam int CountWidth    = $clog2(BinWidth);
   localparam int CharWidth     = 8;

   localparam logic [DigitIdxWidth-1:0] LastDigitIdx = DigitIdxWidth'(NumDigits - 1);
   localparam logic [CountWidth-1:0]    LastShift    = CountWidth'(BinWidth - 1);

   // ASCII codes
   localparam logic [CharWidth-1:0] CharDigitBase = 8'h30;
   localparam logic [CharWidth-1:0] CharMinus     = 8'h2D;
   localparam logic [CharWidth-1:0] CharPlus      = 8'h2B;
   localparam logic [CharWidth-1:0] CharSpace     = 8'h20;

   // sign modes
   localparam logic [1:0] SignModeNone  = 2'd0;
   localparam logic [1:0] SignModePlus  = 2'd1;
   localparam logic [1:0] SignModeSpace = 2'd2;

   typedef struct packed {
      logic signed [BinWidth-1:0] value;
      logic [1:0]                 sign_mode;
   } req_type;

   typedef struct packed {
      logic [CharWidth-1:0] character;
      logic                 last;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic shift;
      logic seek;
      logic emit_sign;
      logic emit_digit;
   } dp_cmd_type;

   typedef struct packed {
      logic has_sign;
      logic last_digit;
   } dp_status_type;

endpackage

// File: hw/rtl/sitoa_dp.sv
// ----------------------------------------------------------------------------
// sitoa_dp
// Datapath: magnitude load, shift-add-3 binary to BCD, digit selection and
// the output character register.
// ----------------------------------------------------------------------------
module sitoa_dp (
   input  logic                     clock,
   input  sitoa_pkg::req_type       req_data,
   input  sitoa_pkg::dp_cmd_type    cmd,
   output sitoa_pkg::dp_status_type status,
   output sitoa_pkg::rsp_type       rsp_data
);

   logic [sitoa_pkg::BinWidth-1:0]                 bin_ff, bin_in;
   logic [sitoa_pkg::NumDigits-1:0][3:0]           bcd_ff, bcd_in;
   logic                                           neg_ff;
   logic [1:0]                                     mode_ff;
   logic [sitoa_pkg::DigitIdxWidth-1:0]            dig_idx_ff;
   sitoa_pkg::rsp_type                             rsp_ff;

   logic [sitoa_pkg::NumDigits-1:0][3:0]           adj;
   logic [sitoa_pkg::DigitIdxWidth-1:0]            msd;
   logic [sitoa_pkg::BinWidth-1:0]                 mag;
   logic [3:0]                                     cur_digit;
   logic [sitoa_pkg::CharWidth-1:0]                sign_char;

   // magnitude; the most negative value wraps to 2^31 in unsigned terms
   assign mag = req_data.value[sitoa_pkg::BinWidth-1]
                ? (~req_data.value + sitoa_pkg::BinWidth'(1))
                : req_data.value;

   // add 3 to every digit of 5 or more, then shift the whole word left
   always_comb begin
      for (int i = 0; i < sitoa_pkg::NumDigits; i++) begin
         adj[i] = (bcd_ff[i] >= 4'd5) ? (bcd_ff[i] + 4'd3) : bcd_ff[i];
      end
      {bcd_in, bin_in} = {adj[sitoa_pkg::NumDigits-1:0], bin_ff} << 1;
   end

   // most significant nonzero digit, zero when the value is zero
   always_comb begin
      msd = '0;
      for (int i = 0; i < sitoa_pkg::NumDigits; i++) begin
         if (bcd_ff[i] != 4'd0) begin
            msd = sitoa_pkg::DigitIdxWidth'(i);
         end
      end
   end

   assign cur_digit = bcd_ff[dig_idx_ff];

   always_comb begin
      priority if (neg_ff) begin
         sign_char = sitoa_pkg::CharMinus;
      end else if (mode_ff == sitoa_pkg::SignModePlus) begin
         sign_char = sitoa_pkg::CharPlus;
      end else begin
         sign_char = sitoa_pkg::CharSpace;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         bin_ff  <= mag;
         bcd_ff  <= '0;
         neg_ff  <= req_data.value[sitoa_pkg::BinWidth-1];
         mode_ff <= req_data.sign_mode;
      end else if (cmd.shift) begin
         bin_ff <= bin_in;
         bcd_ff <= bcd_in;
      end
      if (cmd.seek) begin
         dig_idx_ff <= msd;
      end else if (cmd.emit_digit && dig_idx_ff != '0) begin
         dig_idx_ff <= dig_idx_ff - sitoa_pkg::DigitIdxWidth'(1);
      end
      if (cmd.emit_sign) begin
         rsp_ff.character <= sign_char;
         rsp_ff.last      <= 1'b0;
      end else if (cmd.emit_digit) begin
         rsp_ff.character <= sitoa_pkg::CharDigitBase + {4'd0, cur_digit};
         rsp_ff.last      <= (dig_idx_ff == '0);
      end
   end

   assign status.has_sign   = neg_ff || (mode_ff == sitoa_pkg::SignModePlus)
                              || (mode_ff == sitoa_pkg::SignModeSpace);
   assign status.last_digit = (dig_idx_ff == '0);
   assign rsp_data          = rsp_ff;

endmodule

// File: hw/rtl/sitoa_ctrl.sv
// ----------------------------------------------------------------------------
// sitoa_ctrl
// Controller: sequences load, 32 conversion shifts, the sign and the digits.
// ----------------------------------------------------------------------------
module sitoa_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  sitoa_pkg::dp_status_type status,
   output sitoa_pkg::dp_cmd_type    cmd,
   output logic                     rsp_strobe
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_PREFIX,
      ST_DIGITS
   } state_type;

   state_type                        state_ff;
   logic [sitoa_pkg::CountWidth-1:0] count_ff;
   logic                             strobe_ff;
   logic                             accept;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   always_comb begin
      cmd            = '0;
      cmd.load       = accept;
      cmd.shift      = (state_ff == ST_CONVERT);
      cmd.seek       = (state_ff == ST_PREFIX);
      cmd.emit_sign  = (state_ff == ST_PREFIX) && status.has_sign;
      cmd.emit_digit = (state_ff == ST_DIGITS);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               count_ff <= '0;
               if (start) begin
                  state_ff <= ST_CONVERT;
               end
            end
            ST_CONVERT: begin
               count_ff <= count_ff + sitoa_pkg::CountWidth'(1);
               if (count_ff == sitoa_pkg::LastShift) begin
                  state_ff <= ST_PREFIX;
               end
            end
            ST_PREFIX: begin
               strobe_ff <= status.has_sign;
               state_ff  <= ST_DIGITS;
            end
            ST_DIGITS: begin
               strobe_ff <= 1'b1;
               if (status.last_digit) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_strobe = strobe_ff;

endmodule

// File: hw/rtl/signed_int_to_decimal_ascii_top.sv
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_top
// Converts a signed 32-bit integer to its decimal ASCII text, one character
// per response, with an optional sign prefix.
// ----------------------------------------------------------------------------
// Usage:
//   Drive req_data (value, sign_mode) and raise start. The request is taken
//   at a rising edge where start is high and busy is low; busy stays high
//   until the last character has been issued.
//   Characters leave on rsp_data, each valid for exactly one cycle while
//   rsp_strobe is high; rsp_data.last marks the final digit. The receiver
//   must take every character as it appears; there is no back-pressure.
//   Output order: '-' for negative values, otherwise '+' (mode 1), ' '
//   (mode 2) or nothing (modes 0 and 3); then the digits, most significant
//   first, without leading zeros.
// Sequence:
//   Shift-add-3 conversion over every bit of the operand, then a step that
//   picks the leading digit (and issues the sign), then one digit per cycle.
//   No new request is taken until the last digit has been issued.
// Reset:
//   Synchronous, active high; returns the controller to idle and drops any
//   request in progress.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  sitoa_pkg::req_type req_data,
   output logic               rsp_strobe,
   output sitoa_pkg::rsp_type rsp_data
);

   sitoa_pkg::dp_cmd_type    cmd;
   sitoa_pkg::dp_status_type status;

   // sequence the conversion and the character stream
   sitoa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .status     (status),
      .cmd        (cmd),
      .rsp_strobe (rsp_strobe)
   );

   // hold the operand, run the BCD shifts and form each character
   sitoa_dp u_dp (
      .clock    (clock),
      .req_data (req_data),
      .cmd      (cmd),
      .status   (status),
      .rsp_data (rsp_data)
   );

   // an accepted request makes the block busy next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after request");

   // no character leaves in the cycle after a request is taken
   a_accept_quiet: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> !rsp_strobe)
      else $error("character issued right after request");

   // characters of one number leave back to back until the last one
   a_stream_gapless: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_data.last) |=> rsp_strobe)
      else $error("gap inside a character stream");

   // the final character is not followed by another one
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.last) |=> !rsp_strobe)
      else $error("character after last");

endmodule
